// ===== sv/wildcard_byte_pattern_scanner_unit_defines.svh =====
// Assertion macros for the wildcard byte pattern scanner checker.
// Expects signals named clk and rst in the scope where a macro is used.
`ifndef WILDCARD_BYTE_PATTERN_SCANNER_UNIT_DEFINES_SVH
`define WILDCARD_BYTE_PATTERN_SCANNER_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define WBPS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wbps assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define WBPS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wbps assertion failed");

`endif

// ===== sv/wbps_pkg.sv =====
// Shared constants, types and helper functions of the wildcard byte scanner.
// No dependencies; imported by the cell, the top level and the checker.
package wbps_pkg;

  localparam int MAX_PATTERN = 16;
  localparam int LEN_W       = 5;
  localparam int IDX_W       = $clog2(MAX_PATTERN);
  localparam int ADDR_W      = 64;
  localparam int CFG_W       = 64;
  localparam int CFG_IDX_W   = 3;
  localparam int MASK_W      = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WILDCARD     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BASE         = 3'd4;

  // What one window cell needs to judge its byte.
  typedef struct packed {
    logic [7:0] pattern;
    logic       care;
  } cell_ctrl_t;

  function automatic logic [7:0] pattern_byte(input logic [CFG_W-1:0] lo,
                                              input logic [CFG_W-1:0] hi,
                                              input logic [IDX_W-1:0] idx);
    logic [2*CFG_W-1:0] both;
    both = {hi, lo};
    return both[idx*8 +: 8];
  endfunction

endpackage

// ===== sv/wbps_cell.sv =====
// One cell of the byte window: holds one byte and compares the byte entering it.
// Depends on wbps_pkg for the cell control struct.
module wbps_cell (
  input  logic                clk,
  input  logic                shift,
  input  logic [7:0]          in_byte,
  input  wbps_pkg::cell_ctrl_t ctrl,
  output logic [7:0]          held_byte,
  output logic                hit
);
  import wbps_pkg::*;

  // The compare looks at the byte this cell takes on the current transfer.
  assign hit = !ctrl.care || (in_byte == ctrl.pattern);

  always_ff @(posedge clk) begin
    if (shift) begin
      held_byte <= in_byte;
    end
  end

endmodule

// ===== sv/wildcard_byte_pattern_scanner_unit.sv =====
// Top level of the wildcard byte pattern scanner: config registers, cell chain,
// match control and output register. Depends on wbps_pkg and wbps_cell.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+--------------------------
//  input    | in_valid / in_stall   | data_byte, last_byte
//  output   | out_valid / out_stall | match_address
//  config   | cfg_write             | cfg_index, cfg_data
//
// A new byte is taken in every cycle while the output register is free or
// being drained, so the rate is one byte per clock.
// The match for a byte shows in out_valid on the cycle after its transfer.
// Reset (rst, synchronous) restores the register reset values and clears
// the fill count, skip count, position and output valid.
// in_stall rises only while a result waits in the output register under
// out_stall; the byte window then holds still.
module wildcard_byte_pattern_scanner_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      data_byte,
  input  logic                            last_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [wbps_pkg::ADDR_W-1:0]     match_address,
  input  logic                            cfg_write,
  input  logic [wbps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wbps_pkg::CFG_W-1:0]      cfg_data
);
  import wbps_pkg::*;

  // Configuration registers.
  logic [CFG_W-1:0]  pat_lo;
  logic [CFG_W-1:0]  pat_hi;
  logic [MASK_W-1:0] wild_mask;
  logic [LEN_W-1:0]  pat_len;
  logic [ADDR_W-1:0] base_address;

  always_ff @(posedge clk) begin
    if (rst) begin
      pat_lo       <= '0;
      pat_hi       <= '0;
      wild_mask    <= '0;
      pat_len      <= LEN_W'(1);
      base_address <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PATTERN_LOW:  pat_lo       <= cfg_data;
        REG_PATTERN_HIGH: pat_hi       <= cfg_data;
        REG_WILDCARD:     wild_mask    <= cfg_data[MASK_W-1:0];
        REG_LENGTH:       pat_len      <= cfg_data[LEN_W-1:0];
        REG_BASE:         base_address <= cfg_data;
        default: ; // Indexes past the register list are ignored.
      endcase
    end
  end

  // Lengths above the window depth act as a full-depth pattern.
  logic [LEN_W-1:0] len_act;
  assign len_act = (pat_len > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : pat_len;

  // Scan state.
  logic [LEN_W-1:0]  fill;
  logic [LEN_W-1:0]  fill_next;
  logic [LEN_W-1:0]  skip;
  logic [ADDR_W-1:0] byte_position;

  logic in_fire;
  assign in_stall = out_valid && out_stall;
  assign in_fire  = in_valid && !in_stall;

  assign fill_next = (fill < LEN_W'(MAX_PATTERN)) ? fill + LEN_W'(1) : fill;

  // Cell k holds the byte of age k. It lines up with pattern byte
  // len_act-1-k, and cells at or past the pattern length always agree.
  cell_ctrl_t       ctrl [MAX_PATTERN];
  logic [7:0]       held [MAX_PATTERN];
  logic [7:0]       feed [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] hits;

  always_comb begin
    logic [LEN_W-1:0] idx;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      idx             = len_act - LEN_W'(1) - LEN_W'(k);
      ctrl[k].pattern = pattern_byte(pat_lo, pat_hi, idx[IDX_W-1:0]);
      ctrl[k].care    = (LEN_W'(k) < len_act) && !wild_mask[idx[IDX_W-1:0]];
    end
  end

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign feed[k] = data_byte;
    end else begin : g_link
      assign feed[k] = held[k-1];
    end
    wbps_cell u_cell (
      .clk       (clk),
      .shift     (in_fire),
      .in_byte   (feed[k]),
      .ctrl      (ctrl[k]),
      .held_byte (held[k]),
      .hit       (hits[k])
    );
  end

  // A compare counts only once the window holds a full pattern's worth of
  // bytes from this region and no earlier match is still being skipped.
  logic match;
  assign match = (skip == '0) && (len_act != '0) && (fill_next >= len_act) && (&hits);

  logic [ADDR_W-1:0] addr_next;
  assign addr_next = base_address + byte_position
                   - {{(ADDR_W-LEN_W){1'b0}}, len_act - LEN_W'(1)};

  always_ff @(posedge clk) begin
    if (rst) begin
      fill          <= '0;
      skip          <= '0;
      byte_position <= '0;
    end else if (in_fire) begin
      if (last_byte) begin
        // End of region: the next byte starts a fresh scan.
        fill          <= '0;
        skip          <= '0;
        byte_position <= '0;
      end else begin
        fill          <= fill_next;
        byte_position <= byte_position + ADDR_W'(1);
        if (skip != '0) begin
          skip <= skip - LEN_W'(1);
        end else if (match) begin
          skip <= len_act - LEN_W'(1);
        end
      end
    end
  end

  // Output register. A new result may replace one that is leaving this cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire && match) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && match) begin
      match_address <= addr_next;
    end
  end

endmodule

// ===== sv/wbps_checker.sv =====
// Port-level checker for the wildcard byte pattern scanner, bound to the top.
// Depends on wbps_pkg and the assertion macros header.
`include "wildcard_byte_pattern_scanner_unit_defines.svh"

module wbps_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic [7:0]                      data_byte,
  input logic                            last_byte,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [wbps_pkg::ADDR_W-1:0]     match_address
);
  import wbps_pkg::*;

  // A result waiting under stall keeps its valid and its address.
  `WBPS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(match_address))

  // The input side stalls exactly while a result is blocked.
  `WBPS_ASSERT_IMP(a_in_stall, 1'b1, in_stall == (out_valid && out_stall))

  // A fresh result needs a byte transfer on the cycle before.
  `WBPS_ASSERT_IMP(a_out_cause, out_valid && !$past(out_valid && out_stall),
                   $past(in_valid && !in_stall))

  // Nothing moves on the input side while it is stalled.
  `WBPS_ASSERT_NEXT(a_in_hold, in_valid && in_stall,
                    in_valid && $stable(data_byte) && $stable(last_byte))

endmodule

bind wildcard_byte_pattern_scanner_unit wbps_checker u_wbps_checker (.*);

// ===== verif/wildcard_byte_pattern_scanner_unit_test.sv =====
// Self-checking testbench for wildcard_byte_pattern_scanner_unit: directed and random byte streams
// against a built-in match predictor, with random idling on both channels.
// Depends on wbps_pkg and the scanner RTL only.
`timescale 1ns / 1ps

module wildcard_byte_pattern_scanner_unit_test;
  import wbps_pkg::*;

  // One byte of a scanned region as the driver offers it.
  typedef struct {
    logic [7:0] data;
    logic       last;
  } scan_item_t;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  logic [7:0]           data_byte = 8'h00;
  logic                 last_byte = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [ADDR_W-1:0]    match_address;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_PATTERN_LOW;
  logic [CFG_W-1:0]     cfg_data  = '0;

  wildcard_byte_pattern_scanner_unit dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .data_byte     (data_byte),
    .last_byte     (last_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .match_address (match_address),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the configuration registers, with their reset values.
  logic [63:0]       pat_lo    = '0;
  logic [63:0]       pat_hi    = '0;
  logic [15:0]       wc_mask   = '0;
  logic [4:0]        pat_len   = 5'd1;
  logic [ADDR_W-1:0] base_addr = '0;

  // Shadow scan state: recent bytes (entry 0 newest), fill, skip count, position.
  logic [7:0]        win [MAX_PATTERN];
  int unsigned       win_fill  = 0;
  int unsigned       skip_left = 0;
  logic [63:0]       pos       = '0;

  // Bytes waiting for the driver, and match addresses still owed by the block.
  scan_item_t        byte_q[$];
  logic [ADDR_W-1:0] match_addr_q[$];

  int   errors = 0;
  bit   idle_on = 1'b1;        // random idling on both channels
  bit   long_hold_req = 1'b0;  // asks the receiver for one long hold-off
  int   gap_left = 0;
  int   hold_left = 0;
  int   burst_left = 0;
  scan_item_t        next_item;
  logic [ADDR_W-1:0] want_addr;

  initial begin
    for (int k = 0; k < MAX_PATTERN; k++) win[k] = 8'h00;
  end

  // Advances the shadow scan by one accepted byte and queues the match address
  // that byte completes, if any. Lengths beyond the window are clipped to it,
  // and a zero length never matches.
  task automatic track_byte(input logic [7:0] b, input logic last);
    int          len;
    bit          hit;
    logic [127:0] pats;
    len  = (pat_len > MAX_PATTERN) ? MAX_PATTERN : int'(pat_len);
    pats = {pat_hi, pat_lo};
    for (int k = MAX_PATTERN - 1; k > 0; k--) win[k] = win[k-1];
    win[0] = b;
    if (win_fill < MAX_PATTERN) win_fill++;
    if (skip_left > 0) begin
      // Still inside the previous match; matches never overlap.
      skip_left--;
    end else if (len > 0 && win_fill >= len) begin
      hit = 1'b1;
      for (int i = 0; i < len; i++) begin
        if (!wc_mask[i] && win[len-1-i] != pats[i*8 +: 8]) hit = 1'b0;
      end
      if (hit) begin
        match_addr_q = {match_addr_q, base_addr + pos - 64'(len - 1)};
        skip_left = len - 1;
      end
    end
    pos++;
    // The end of a region drops any partial match and restarts addressing.
    if (last) begin
      for (int k = 0; k < MAX_PATTERN; k++) win[k] = 8'h00;
      win_fill  = 0;
      skip_left = 0;
      pos       = '0;
    end
  endtask

  // Input driver. A transfer at this edge is fed to the predictor; the next
  // byte is presented only once the current one has gone, so a stalled
  // payload never changes and valid never looks at stall.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) track_byte(data_byte, last_byte);
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
          // An idle gap starts here; gap_left counts the idle cycles still to come.
          gap_left = $urandom_range(0, 11);
          in_valid <= 1'b0;
        end else if (byte_q.size() > 0) begin
          next_item = byte_q.pop_front();
          in_valid  <= 1'b1;
          data_byte <= next_item.data;
          last_byte <= next_item.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output stall generator: bursts of random length, either stalled or
  // flowing, plus one long hold-off on request that backs the block up.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (long_hold_req) begin
      long_hold_req = 1'b0;
      hold_left     = 299;
      out_stall <= 1'b1;
    end else if (!idle_on) begin
      out_stall <= 1'b0;
    end else if (burst_left > 0) begin
      burst_left--;
    end else begin
      out_stall <= ($urandom_range(0, 2) == 0);
      burst_left = $urandom_range(0, 11);
    end
  end

  // Result monitor: every output transfer must match the oldest owed address.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (match_addr_q.size() == 0) begin
        $error("match_address: expected none, actual %h", match_address);
        errors++;
      end else begin
        want_addr = match_addr_q.pop_front();
        if (match_address !== want_addr) begin
          $error("match_address: expected %h, actual %h", want_addr, match_address);
          errors++;
        end
      end
    end
  end

  // Configuration writes happen only while the block is idle. The shadow copy
  // keeps the same bits the register does.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_PATTERN_LOW:  pat_lo    = val;
      REG_PATTERN_HIGH: pat_hi    = val;
      REG_WILDCARD:     wc_mask   = val[15:0];
      REG_LENGTH:       pat_len   = val[4:0];
      REG_BASE:         base_addr = val;
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  function automatic void push_byte(input logic [7:0] b, input logic last);
    scan_item_t it;
    it.data = b;
    it.last = last;
    byte_q = {byte_q, it};
  endfunction

  // Waits until every byte has gone in and every owed match has come out,
  // then lets the pipeline settle. A match that never shows is a failure.
  task automatic settle();
    int waited;
    do @(negedge clk); while (byte_q.size() != 0 || in_valid);
    waited = 0;
    while (match_addr_q.size() != 0 && waited < 4000) begin
      @(negedge clk);
      waited++;
    end
    if (match_addr_q.size() != 0) begin
      $error("match_address: %0d expected results never arrived", match_addr_q.size());
      errors++;
      match_addr_q.delete();
    end
    repeat (4) @(negedge clk);
  endtask

  // Random configuration. Short patterns dominate so matches are frequent;
  // zero, full-window and over-long lengths show up now and then. Unused
  // high bits of the narrow registers sometimes carry junk.
  task automatic random_config();
    logic [CFG_W-1:0] val;
    int               r;
    r = $urandom_range(0, 19);
    write_reg(REG_PATTERN_LOW, {$urandom, $urandom});
    write_reg(REG_PATTERN_HIGH, {$urandom, $urandom});
    val = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0: val[15:0] = 16'h0000;
      1: val[15:0] = 16'($urandom);
      2: val[15:0] = 16'($urandom & $urandom & $urandom);
      default: val[15:0] = 16'hFFFF;
    endcase
    if ($urandom_range(0, 1) == 0) val[63:16] = '0;
    write_reg(REG_WILDCARD, val);
    val = {$urandom, $urandom};
    if (r == 0)      val[4:0] = 5'd0;
    else if (r == 1) val[4:0] = 5'd16;
    else if (r == 2) val[4:0] = 5'($urandom_range(17, 31));
    else             val[4:0] = 5'($urandom_range(1, 6));
    if ($urandom_range(0, 1) == 0) val[63:5] = '0;
    write_reg(REG_LENGTH, val);
    if ($urandom_range(0, 2) == 0)
      write_reg(REG_BASE, 64'hFFFF_FFFF_FFFF_FFF0 | 64'($urandom_range(0, 15)));
    else
      write_reg(REG_BASE, {$urandom, $urandom});
    end_writes();
  endtask

  // Random stream for the current pattern: mostly copies of the pattern with
  // random bytes under the wildcards, some with one byte broken or the region
  // ending inside them, mixed with runs of noise and near misses.
  function automatic void queue_scan_stream(input int n);
    int           made;
    int           len;
    int           cut;
    int           bad;
    logic [127:0] pats;
    logic [7:0]   b;
    logic         last;
    len  = (pat_len > MAX_PATTERN) ? MAX_PATTERN : int'(pat_len);
    pats = {pat_hi, pat_lo};
    made = 0;
    while (made < n) begin
      if (len > 0 && $urandom_range(0, 9) < 7) begin
        cut = ($urandom_range(0, 15) == 0) ? $urandom_range(0, len - 1) : -1;
        bad = ($urandom_range(0, 7) == 0) ? $urandom_range(0, len - 1) : -1;
        for (int j = 0; j < len; j++) begin
          b = wc_mask[j] ? 8'($urandom) : pats[j*8 +: 8];
          if (j == bad) b = b ^ 8'($urandom_range(1, 255));
          last = (j == cut) || (j == len - 1 && $urandom_range(0, 5) == 0);
          push_byte(b, last);
          made++;
        end
      end else begin
        repeat ($urandom_range(1, 8)) begin
          b = ($urandom_range(0, 3) == 0) ? pats[7:0] : 8'($urandom);
          push_byte(b, $urandom_range(0, 49) == 0);
          made++;
        end
      end
    end
  endfunction

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset configuration: a single zero byte is the whole pattern.
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b1);
    settle();

    // Four-byte pattern FF ?? 5A 80 with the base at the top of the address
    // space, so the match addresses wrap. Two back-to-back matches, then a
    // partial match cut off by the end of the region.
    write_reg(REG_PATTERN_LOW, 64'h0000_0000_805A_00FF);
    write_reg(REG_PATTERN_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_WILDCARD, 64'h0000_0000_0000_0002);
    write_reg(REG_LENGTH, 64'd4);
    write_reg(REG_BASE, 64'hFFFF_FFFF_FFFF_FFFF);
    end_writes();
    push_byte(8'hFF, 1'b0);
    push_byte(8'h12, 1'b0);
    push_byte(8'h5A, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h5A, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h33, 1'b0);
    push_byte(8'h5A, 1'b1);
    settle();

    // An empty pattern never matches, even with every byte a wildcard.
    write_reg(REG_LENGTH, 64'd0);
    write_reg(REG_WILDCARD, 64'h0000_0000_0000_FFFF);
    end_writes();
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h5A, 1'b1);
    settle();

    // Random phases. Regions may stay open across a phase boundary, so some
    // configuration changes land inside a region. Phase 3 matches every byte
    // while the receiver holds off for a long time, which backs the block up
    // into its input. The last phases run without any idling.
    for (int ph = 0; ph < 12; ph++) begin
      idle_on = (ph < 10) && (ph % 4 != 2);
      if (ph == 3) begin
        write_reg(REG_LENGTH, 64'd1);
        write_reg(REG_WILDCARD, 64'h0000_0000_0000_FFFF);
        end_writes();
        long_hold_req = 1'b1;
      end else begin
        random_config();
      end
      queue_scan_stream(150);
      settle();
    end

    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("** wildcard_byte_pattern_scanner_unit: PASSED **");
    end else begin
      $display("** wildcard_byte_pattern_scanner_unit: FAILED **");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("** wildcard_byte_pattern_scanner_unit: FAILED **");
    $finish;
  end

endmodule

// ===== wildcard_byte_pattern_scanner_unit.f =====
+incdir+sv
sv/wbps_pkg.sv
sv/wbps_cell.sv
sv/wildcard_byte_pattern_scanner_unit.sv
sv/wbps_checker.sv
verif/wildcard_byte_pattern_scanner_unit_test.sv
